// ----- design/msfr_pkg.sv -----
// Package for the serial frame receiver: frame constants, event codes
// and the result record type. No dependencies.
`timescale 1ns / 1ps

package msfr_pkg;

   // Default receive buffer size in bytes
   localparam int BUFFER_BYTES = 64;

   // Frame framing and decode constants
   localparam logic [7:0] START_BYTE     = 8'h55;
   localparam logic [7:0] SECOND_BYTE    = 8'hAA;
   localparam logic [7:0] STATUS_VERSION = 8'h03;
   localparam logic [7:0] STATUS_COMMAND = 8'h07;
   localparam logic [7:0] MODE_DATAPOINT = 8'h04;
   localparam int         HEADER_LEN     = 7;

   // Frame event codes
   localparam logic [1:0] EV_STATUS   = 2'd0;
   localparam logic [1:0] EV_OTHER    = 2'd1;
   localparam logic [1:0] EV_CHECKSUM = 2'd2;

   // One decoded frame
   typedef struct packed {
      logic [1:0]         frame_event;
      logic [7:0]         version_byte;
      logic [7:0]         command_byte;
      logic [7:0]         datapoint_id;
      logic signed [31:0] value_word;
      logic [7:0]         value_byte;
      logic               mode_reset_request;
   } rsp_type;

endpackage

// ----- design/mcu_serial_frame_receiver.sv -----
// Serial frame receiver top level: start hunt, header capture, checksum
// and status-report decode. Depends on msfr_pkg.
`timescale 1ns / 1ps

// Usage
//   req_ channel: one received link byte per transfer (req_rx_byte).
//   rsp_ channel: one decoded frame per completed frame; bytes that do not
//   close a frame give no transfer on rsp_.
//   Each byte is processed in the cycle it is accepted: a byte per cycle,
//   sustained while req_ready is high. The result for a closing byte is
//   registered into the output register, or into the skid slot while
//   that register holds an untaken result; rsp_ shows the output register.
//   Until 0x55 is seen, bytes are discarded. A frame closes when 7 plus the
//   length byte have been collected with 0xAA as second byte; a partial
//   frame that reaches BUFFER_BYTES-1 bytes is dropped.
//   Reset clears the byte count, sum, tail window and both output slots;
//   the captured header bytes are not cleared.
//   When the rsp_ side stalls, a second result slot absorbs one more frame;
//   req_ready drops only while both slots are full, so bytes keep flowing
//   while a single result waits.
module mcu_serial_frame_receiver #(
   parameter int BUFFER_BYTES = msfr_pkg::BUFFER_BYTES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_frame_event,
   output logic [7:0]         rsp_version_byte,
   output logic [7:0]         rsp_command_byte,
   output logic [7:0]         rsp_datapoint_id,
   output logic signed [31:0] rsp_value_word,
   output logic [7:0]         rsp_value_byte,
   output logic               rsp_mode_reset_request
);

   localparam int CW = $clog2(BUFFER_BYTES);
   localparam int HL = msfr_pkg::HEADER_LEN;

   // Frame state
   logic [CW-1:0] fill_ff, fill_in;
   logic [7:0]    sum_ff, sum_in;
   logic [31:0]   tail_ff, tail_in;
   logic [7:0]    hdr_ff [HL];

   // Output register and skid slot
   logic              rsp_valid_ff, rsp_valid_in;
   msfr_pkg::rsp_type rsp_ff, rsp_in;
   logic              skid_valid_ff, skid_valid_in;
   msfr_pkg::rsp_type skid_ff, skid_in;

   logic              accept;
   logic              started;
   logic              done;
   logic              status;
   logic [CW-1:0]     fill_inc;
   logic [8:0]        frame_len;
   logic [7:0]        dp;
   logic              out_take;
   msfr_pkg::rsp_type res;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_take  = rsp_valid_ff && rsp_ready;

   // Frame detection on the incoming byte
   always_comb begin
      started   = (fill_ff != '0) || (req_rx_byte == msfr_pkg::START_BYTE);
      fill_inc  = fill_ff + 1'b1;
      frame_len = 9'(HL) + {1'b0, hdr_ff[5]};
      done      = started && (fill_ff >= CW'(HL - 1))
                  && (hdr_ff[0] == msfr_pkg::START_BYTE)
                  && (hdr_ff[1] == msfr_pkg::SECOND_BYTE)
                  && (9'(fill_inc) == frame_len);
      // empty payload: the seventh byte is the closing byte itself
      dp     = (fill_ff == CW'(HL - 1)) ? req_rx_byte : hdr_ff[HL-1];
      status = (req_rx_byte == sum_ff)
               && (hdr_ff[2] == msfr_pkg::STATUS_VERSION)
               && (hdr_ff[3] == msfr_pkg::STATUS_COMMAND);
   end

   // Decoded result
   always_comb begin
      res              = '0;
      res.version_byte = hdr_ff[2];
      res.command_byte = hdr_ff[3];
      if (req_rx_byte != sum_ff) begin
         res.frame_event = msfr_pkg::EV_CHECKSUM;
      end else if (status) begin
         res.frame_event        = msfr_pkg::EV_STATUS;
         res.datapoint_id       = dp;
         res.value_word         = tail_ff;
         res.value_byte         = tail_ff[7:0];
         res.mode_reset_request = (dp == msfr_pkg::MODE_DATAPOINT)
                                  && (tail_ff[7:0] != 8'h00);
      end else begin
         res.frame_event = msfr_pkg::EV_OTHER;
      end
   end

   // Count, sum and tail window
   always_comb begin
      fill_in = fill_ff;
      sum_in  = sum_ff;
      tail_in = tail_ff;
      if (accept && started) begin
         if (done) begin
            fill_in = '0;
            sum_in  = '0;
            tail_in = '0;
         end else begin
            fill_in = fill_inc;
            sum_in  = sum_ff + req_rx_byte;
            tail_in = {tail_ff[23:0], req_rx_byte};
            if (fill_inc >= CW'(BUFFER_BYTES - 1)) begin
               fill_in = '0;
               sum_in  = '0;
               tail_in = '0;
            end
         end
      end
   end

   // Output register and skid slot
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept && done) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         sum_ff        <= '0;
         tail_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         sum_ff        <= sum_in;
         tail_ff       <= tail_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers and header capture
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
      if (accept && started && (fill_ff < CW'(HL))) begin
         hdr_ff[fill_ff[2:0]] <= req_rx_byte;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_frame_event        = rsp_ff.frame_event;
   assign rsp_version_byte       = rsp_ff.version_byte;
   assign rsp_command_byte       = rsp_ff.command_byte;
   assign rsp_datapoint_id       = rsp_ff.datapoint_id;
   assign rsp_value_word         = rsp_ff.value_word;
   assign rsp_value_byte         = rsp_ff.value_byte;
   assign rsp_mode_reset_request = rsp_ff.mode_reset_request;

   // Checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid slot full while output register empty");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff < CW'(BUFFER_BYTES - 1))
      else $error("fill count beyond buffer limit");

   a_non_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.frame_event != msfr_pkg::EV_STATUS)) |->
      (rsp_ff.datapoint_id == 8'h00 && rsp_ff.value_word == 32'sd0 &&
       rsp_ff.value_byte == 8'h00 && !rsp_ff.mode_reset_request))
      else $error("status fields set on a non-status frame");

   a_mode_reset_dp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.mode_reset_request) |->
      (rsp_ff.datapoint_id == msfr_pkg::MODE_DATAPOINT))
      else $error("mode reset request on wrong datapoint");

   a_skid_fills_on_stall: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !$past(skid_valid_ff)) |-> $past(rsp_valid_ff && !rsp_ready))
      else $error("skid slot filled without a stall");

endmodule
